>>> rtl/key_debounce_event_detector_macros.svh
// Assertion macros for the key debounce event detector.
// Expects clk and arst_n in the scope where a macro is used; needs nothing else.
`ifndef KEY_DEBOUNCE_EVENT_DETECTOR_MACROS_SVH
`define KEY_DEBOUNCE_EVENT_DETECTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KDE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("key debounce assertion failed");

// Next-cycle implication, checked outside reset.
`define KDE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("key debounce assertion failed");

`endif

>>> rtl/kde_pkg.sv
// Shared types and constants for the key debounce event detector.
// Used by kde_cfg, kde_step and the top level; depends on nothing.
package kde_pkg;

	localparam int unsigned UNIT_TICKS = 100;
	localparam int unsigned THR_W      = 15;  // 255 * 100 fits in 15 bits
	localparam int unsigned IDX_W      = 3;
	localparam int unsigned DATA_W     = 16;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_DEBOUNCE = 3'd0;
	localparam logic [IDX_W-1:0] REG_PRESS    = 3'd1;
	localparam logic [IDX_W-1:0] REG_DOUBLE   = 3'd2;
	localparam logic [IDX_W-1:0] REG_LONG     = 3'd3;
	localparam logic [IDX_W-1:0] REG_HOLD     = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_PRESS  = 3'd1,
		ST_DOWN   = 3'd2,
		ST_DOUBLE = 3'd3,
		ST_LONG   = 3'd4,
		ST_HOLD   = 3'd5,
		ST_UP     = 3'd6
	} key_state_t;

	// Timing limits in ticks; the four thresholds are scaled from 100-tick units, debounce is not.
	typedef struct packed {
		logic [15:0]      debounce;
		logic [THR_W-1:0] press_thr;
		logic [THR_W-1:0] double_thr;
		logic [THR_W-1:0] long_thr;
		logic [THR_W-1:0] hold_thr;
	} timing_t;

	// Result of one tick step.
	typedef struct packed {
		key_state_t key_state;
		logic       changed;
		logic       stable;
		logic       raw_edge;
	} step_res_t;

endpackage

>>> rtl/kde_cfg.sv
// Configuration registers; threshold unit counts are scaled to ticks when written.
// Depends on kde_pkg.
module kde_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [kde_pkg::IDX_W-1:0]   wr_index,
	input  logic [kde_pkg::DATA_W-1:0]  wr_data,
	output kde_pkg::timing_t            timing
);

	kde_pkg::timing_t timing_q;
	logic [kde_pkg::THR_W-1:0] scaled;

	// Eight-bit unit count times 100; the product stays below 2^15.
	assign scaled = kde_pkg::THR_W'(wr_data[7:0]) * kde_pkg::THR_W'(kde_pkg::UNIT_TICKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.debounce   <= 16'd20;
			timing_q.press_thr  <= kde_pkg::THR_W'(1 * kde_pkg::UNIT_TICKS);
			timing_q.double_thr <= kde_pkg::THR_W'(3 * kde_pkg::UNIT_TICKS);
			timing_q.long_thr   <= kde_pkg::THR_W'(10 * kde_pkg::UNIT_TICKS);
			timing_q.hold_thr   <= kde_pkg::THR_W'(20 * kde_pkg::UNIT_TICKS);
		end else if (wr_en) begin
			unique case (wr_index)
				kde_pkg::REG_DEBOUNCE: timing_q.debounce   <= wr_data;
				kde_pkg::REG_PRESS:    timing_q.press_thr  <= scaled;
				kde_pkg::REG_DOUBLE:   timing_q.double_thr <= scaled;
				kde_pkg::REG_LONG:     timing_q.long_thr   <= scaled;
				kde_pkg::REG_HOLD:     timing_q.hold_thr   <= scaled;
				default: ;
			endcase
		end
	end

	assign timing = timing_q;

endmodule

>>> rtl/kde_step.sv
// Tick counter, edge tracking, debounce and the key event state machine.
// Depends on kde_pkg; one tick is stepped in every cycle that step_en is high.
module kde_step #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  logic                  key_level,
	input  kde_pkg::timing_t      timing,
	output kde_pkg::step_res_t    res
);

	logic [TIME_BITS-1:0] tick_q, edge_time_q, click_time_q;
	logic                 last_raw_q, debounced_q;
	kde_pkg::key_state_t  state_q, prior_q, state_nxt;

	logic [TIME_BITS-1:0] since_edge, since_click;
	logic                 raw_edge, settled;
	logic                 press_done, long_done, hold_done, is_double;
	logic                 click_set;

	assign raw_edge    = key_level != last_raw_q;
	assign since_edge  = tick_q - edge_time_q;
	assign since_click = tick_q - click_time_q;
	assign settled     = !raw_edge && (since_edge > TIME_BITS'(timing.debounce));
	assign press_done  = since_edge > TIME_BITS'(timing.press_thr);
	assign long_done   = since_edge > TIME_BITS'(timing.long_thr);
	assign hold_done   = since_edge > TIME_BITS'(timing.hold_thr);
	assign is_double   = since_click < TIME_BITS'(timing.double_thr);

	// Next event state; the machine moves only on a settled level.
	always_comb begin
		state_nxt = state_q;
		if (settled) begin
			if (key_level) begin
				unique case (state_q)
					kde_pkg::ST_IDLE:  state_nxt = kde_pkg::ST_PRESS;
					kde_pkg::ST_PRESS: begin
						if (press_done) begin
							state_nxt = is_double ? kde_pkg::ST_DOUBLE : kde_pkg::ST_DOWN;
						end
					end
					kde_pkg::ST_DOWN:  if (long_done) state_nxt = kde_pkg::ST_LONG;
					kde_pkg::ST_LONG:  if (hold_done) state_nxt = kde_pkg::ST_HOLD;
					default:           state_nxt = state_q;
				endcase
			end else begin
				unique case (state_q)
					kde_pkg::ST_IDLE: state_nxt = kde_pkg::ST_IDLE;
					kde_pkg::ST_UP:   state_nxt = kde_pkg::ST_IDLE;
					default:          state_nxt = kde_pkg::ST_UP;
				endcase
			end
		end
	end

	// Outputs of the step: click time capture and the result of this tick.
	always_comb begin
		click_set    = settled && key_level && (state_q == kde_pkg::ST_PRESS)
			&& press_done && !is_double;
		res.key_state = state_nxt;
		res.changed   = !raw_edge && (prior_q != state_nxt);
		res.stable    = settled ? key_level : debounced_q;
		res.raw_edge  = raw_edge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= '0;
			edge_time_q  <= '0;
			click_time_q <= '0;
			last_raw_q   <= 1'b0;
			debounced_q  <= 1'b0;
			state_q      <= kde_pkg::ST_IDLE;
			prior_q      <= kde_pkg::ST_IDLE;
		end else if (step_en) begin
			tick_q <= tick_q + TIME_BITS'(1);
			if (raw_edge) begin
				last_raw_q  <= key_level;
				edge_time_q <= tick_q;
			end else begin
				prior_q <= state_nxt;
			end
			if (settled) begin
				debounced_q <= key_level;
			end
			state_q <= state_nxt;
			if (click_set) begin
				click_time_q <= tick_q;
			end
		end
	end

endmodule

>>> rtl/key_debounce_event_detector.sv
// Key debounce and event detector: the result of each accepted tick is registered.
// Throughput one tick item per cycle while the result channel is not stalled; the tick
// step is a single combinational pass from the state registers to the output register.
// Reset (arst_n low) clears the tick counter, edge and click times, the machine
// to idle and the output valid flag, and loads the timing registers with defaults.
// Depends on kde_pkg, kde_cfg, kde_step and the assertion macro header.
`include "key_debounce_event_detector_macros.svh"

module key_debounce_event_detector #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write channel.
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [kde_pkg::IDX_W-1:0]   cfg_index,
	input  logic [kde_pkg::DATA_W-1:0]  cfg_data,
	// Tick input channel.
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        key_level,
	// Result channel.
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  key_state,
	output logic                        state_changed,
	output logic                        stable_level
);

	kde_pkg::timing_t   timing;
	kde_pkg::step_res_t res;

	logic       in_xfer;
	logic       out_valid_q;
	logic [2:0] key_state_q;
	logic       state_changed_q;
	logic       stable_level_q;

	// Configuration writes are always accepted. They are to be issued only while no
	// tick is in flight; the block itself does not enforce this, and never stalls them.
	assign cfg_ready = 1'b1;

	kde_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.timing   (timing)
	);

	// A new tick can be taken whenever the output register is empty or its
	// result is being transferred out in the same cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	kde_step #(
		.TIME_BITS (TIME_BITS)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (in_xfer),
		.key_level (key_level),
		.timing    (timing),
		.res       (res)
	);

	// Output register: the valid flag is control state, the payload is not reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			key_state_q     <= res.key_state;
			state_changed_q <= res.changed;
			stable_level_q  <= res.stable;
		end
	end

	assign out_valid     = out_valid_q;
	assign key_state     = key_state_q;
	assign state_changed = state_changed_q;
	assign stable_level  = stable_level_q;

	// Every accepted tick leaves a result waiting in the output register.
	`KDE_ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_valid_q)
	// A tick that only records a raw edge never reports a state change.
	`KDE_ASSERT_NEXT(a_edge_no_change, in_xfer && res.raw_edge, !state_changed_q)
	// With a released debounced level the machine is only ever idle or up.
	`KDE_ASSERT_NOW(a_released_state, out_valid_q && !stable_level_q,
		key_state_q == kde_pkg::ST_IDLE || key_state_q == kde_pkg::ST_UP)

endmodule
